// ===== hw/rtl/note_end_time_queue_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the note end time queue.
// Each use expands to one labeled concurrent assertion, clocked on the given
// clock and disabled while the given active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef NOTE_END_TIME_QUEUE_CORE_ASSERT_SVH
`define NOTE_END_TIME_QUEUE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NETQ_ASSERT_IMP(name, clk_sig, rstn_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
    else $error("netq: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define NETQ_ASSERT_NXT(name, clk_sig, rstn_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
    else $error("netq: next-cycle check failed");

`endif

// ===== hw/rtl/netq_pkg.sv =====
// ----------------------------------------------------------------------------
// netq_pkg
// Shared sizes, command codes and controller/datapath types for the note end
// time queue.
// ----------------------------------------------------------------------------
package netq_pkg;

  // Queue depth and derived index widths.
  localparam int MAX_NOTES = 16;
  localparam int IDX_W     = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CNT_W     = $clog2(MAX_NOTES + 1);
  localparam int SUM_W     = CNT_W + 1;

  // Field widths.
  localparam int CMD_W  = 2;
  localparam int KEY_W  = 7;
  localparam int TIME_W = 32;

  // Request command codes.
  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SKIP    = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_LOOKUP,
    DP_WALK,
    DP_ADV_DIFF,
    DP_ADV_POP,
    DP_SKIP,
    DP_REFUSE
  } dp_op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WALK,
    ST_DIFF,
    ST_POP,
    ST_RESP
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [CMD_W-1:0] req_cmd;
    logic             full;
    logic             walk_last;
  } dp_stat_t;

endpackage

// ===== hw/rtl/netq_if.sv =====
// ----------------------------------------------------------------------------
// netq channel interfaces
// Valid/ready channels for requests into and results out of the queue.
// ----------------------------------------------------------------------------
interface netq_in_if;
  logic                           valid;
  logic                           ready;
  logic [netq_pkg::CMD_W-1:0]     command;
  logic [netq_pkg::KEY_W-1:0]     note_key;
  logic [netq_pkg::TIME_W-1:0]    duration;
  logic [netq_pkg::TIME_W-1:0]    sample_count;

  modport source (output valid, output command, output note_key, output duration,
                  output sample_count, input ready);
  modport sink   (input valid, input command, input note_key, input duration,
                  input sample_count, output ready);
endinterface

interface netq_out_if;
  logic                           valid;
  logic                           ready;
  logic                           success;
  logic [netq_pkg::KEY_W-1:0]     ended_key;
  logic [netq_pkg::TIME_W-1:0]    samples_advanced;

  modport source (output valid, output success, output ended_key,
                  output samples_advanced, input ready);
  modport sink   (input valid, input success, input ended_key,
                  input samples_advanced, output ready);
endinterface

// ===== hw/rtl/netq_ctrl.sv =====
// ----------------------------------------------------------------------------
// netq_ctrl
// Sequencer for the note end time queue. Takes one request at a time, steps
// the datapath through its operations and owns the result valid flag.
// ----------------------------------------------------------------------------
module netq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output netq_pkg::dp_cmd_t  cmd,
  input  netq_pkg::dp_stat_t stat
);

  netq_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      netq_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = netq_pkg::ST_DECODE;
      end
      netq_pkg::ST_DECODE: begin
        priority if (stat.req_cmd == netq_pkg::CMD_START && !stat.full) begin
          state_nxt = netq_pkg::ST_WALK;
        end else if (stat.req_cmd == netq_pkg::CMD_ADVANCE) begin
          state_nxt = netq_pkg::ST_DIFF;
        end else begin
          state_nxt = netq_pkg::ST_RESP;
        end
      end
      netq_pkg::ST_WALK: begin
        if (stat.walk_last) state_nxt = netq_pkg::ST_RESP;
      end
      netq_pkg::ST_DIFF: state_nxt = netq_pkg::ST_POP;
      netq_pkg::ST_POP:  state_nxt = netq_pkg::ST_RESP;
      netq_pkg::ST_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = netq_pkg::ST_IDLE;
      end
      default: state_nxt = netq_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands for each state.
  always_comb begin
    cmd.op       = netq_pkg::DP_NOP;
    cmd.out_load = 1'b0;
    unique case (state_r)
      netq_pkg::ST_IDLE: begin
        if (in_valid) cmd.op = netq_pkg::DP_LOAD;
      end
      netq_pkg::ST_DECODE: begin
        priority if (stat.req_cmd == netq_pkg::CMD_START && !stat.full) begin
          cmd.op = netq_pkg::DP_LOOKUP;
        end else if (stat.req_cmd == netq_pkg::CMD_ADVANCE) begin
          cmd.op = netq_pkg::DP_LOOKUP;
        end else if (stat.req_cmd == netq_pkg::CMD_SKIP) begin
          cmd.op = netq_pkg::DP_SKIP;
        end else begin
          // A full queue on start, or an unknown command.
          cmd.op = netq_pkg::DP_REFUSE;
        end
      end
      netq_pkg::ST_WALK: cmd.op = netq_pkg::DP_WALK;
      netq_pkg::ST_DIFF: cmd.op = netq_pkg::DP_ADV_DIFF;
      netq_pkg::ST_POP:  cmd.op = netq_pkg::DP_ADV_POP;
      netq_pkg::ST_RESP: cmd.out_load = !out_valid_r || out_ready;
      default: cmd.op = netq_pkg::DP_NOP;
    endcase
  end

  // The result register stays full until the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= netq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == netq_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/netq_datapath.sv =====
// ----------------------------------------------------------------------------
// netq_datapath
// Time counter, ring of pending notes held in a small memory, insertion walk
// and the result registers of the note end time queue.
// ----------------------------------------------------------------------------
`include "note_end_time_queue_core_assert.svh"

module netq_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  netq_pkg::dp_cmd_t               cmd,
  output netq_pkg::dp_stat_t              stat,
  input  logic [netq_pkg::CMD_W-1:0]      in_command,
  input  logic [netq_pkg::KEY_W-1:0]      in_note_key,
  input  logic [netq_pkg::TIME_W-1:0]     in_duration,
  input  logic [netq_pkg::TIME_W-1:0]     in_sample_count,
  output logic                            out_success,
  output logic [netq_pkg::KEY_W-1:0]      out_ended_key,
  output logic [netq_pkg::TIME_W-1:0]     out_samples_advanced
);

  // Ring slot of queue position idx, counted from head.
  function automatic logic [netq_pkg::IDX_W-1:0] slot_of(
    input logic [netq_pkg::IDX_W-1:0] head,
    input logic [netq_pkg::CNT_W-1:0] idx
  );
    logic [netq_pkg::SUM_W-1:0] sum;
    sum = {{(netq_pkg::SUM_W - netq_pkg::IDX_W){1'b0}}, head} + {1'b0, idx};
    if (sum >= netq_pkg::SUM_W'(netq_pkg::MAX_NOTES)) begin
      sum = sum - netq_pkg::SUM_W'(netq_pkg::MAX_NOTES);
    end
    return sum[netq_pkg::IDX_W-1:0];
  endfunction

  // Queue state.
  logic [netq_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [netq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [netq_pkg::IDX_W-1:0]  head_r, head_nxt;

  // Captured request.
  logic [netq_pkg::CMD_W-1:0]  req_cmd_r;
  logic [netq_pkg::KEY_W-1:0]  req_key_r;
  logic [netq_pkg::TIME_W-1:0] req_end_r;
  logic [netq_pkg::TIME_W-1:0] req_count_r;

  // Ring memory and its registered read port.
  logic [netq_pkg::TIME_W-1:0] mem_end [netq_pkg::MAX_NOTES];
  logic [netq_pkg::KEY_W-1:0]  mem_key [netq_pkg::MAX_NOTES];
  logic [netq_pkg::IDX_W-1:0]  rd_addr;
  logic [netq_pkg::TIME_W-1:0] rd_end_r;
  logic [netq_pkg::KEY_W-1:0]  rd_key_r;
  logic                        wr_en;
  logic [netq_pkg::IDX_W-1:0]  wr_addr;
  logic [netq_pkg::TIME_W-1:0] wr_end;
  logic [netq_pkg::KEY_W-1:0]  wr_key;

  // Insertion walk.
  logic [netq_pkg::CNT_W-1:0]  idx_r;
  logic                        ins_r;
  logic [netq_pkg::TIME_W-1:0] carry_end_r;
  logic [netq_pkg::KEY_W-1:0]  carry_key_r;
  logic                        walk_last;
  logic                        place_new;

  // Advance.
  logic [netq_pkg::TIME_W-1:0] diff_r;
  logic                        adv_hit;

  // Result staging and output registers.
  logic                        res_success_r, res_success_nxt;
  logic [netq_pkg::KEY_W-1:0]  res_key_r, res_key_nxt;
  logic [netq_pkg::TIME_W-1:0] res_adv_r, res_adv_nxt;
  logic                        out_success_r;
  logic [netq_pkg::KEY_W-1:0]  out_key_r;
  logic [netq_pkg::TIME_W-1:0] out_adv_r;

  // Walk decisions: the new note goes ahead of the first entry that does not
  // end earlier, or at the tail when no such entry exists.
  assign walk_last = (idx_r == count_r);
  assign place_new = !ins_r && (walk_last || (rd_end_r >= req_end_r));
  assign adv_hit   = (count_r != '0) && (diff_r <= req_count_r);

  // Memory addressing. The walk reads one position ahead of the one it writes.
  always_comb begin
    unique case (cmd.op)
      netq_pkg::DP_WALK: rd_addr = slot_of(head_r, idx_r + netq_pkg::CNT_W'(1));
      default:           rd_addr = head_r;
    endcase
    wr_en   = (cmd.op == netq_pkg::DP_WALK) && (ins_r || place_new);
    wr_addr = slot_of(head_r, idx_r);
    wr_end  = place_new ? req_end_r : carry_end_r;
    wr_key  = place_new ? req_key_r : carry_key_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_end[wr_addr] <= wr_end;
      mem_key[wr_addr] <= wr_key;
    end
    rd_end_r <= mem_end[rd_addr];
    rd_key_r <= mem_key[rd_addr];
  end

  // Next values of the queue state and the staged result.
  always_comb begin
    time_nxt        = time_r;
    count_nxt       = count_r;
    head_nxt        = head_r;
    res_success_nxt = res_success_r;
    res_key_nxt     = res_key_r;
    res_adv_nxt     = res_adv_r;
    unique case (cmd.op)
      netq_pkg::DP_WALK: begin
        if (walk_last) begin
          count_nxt       = count_r + netq_pkg::CNT_W'(1);
          res_success_nxt = 1'b1;
          res_key_nxt     = '0;
          res_adv_nxt     = '0;
        end
      end
      netq_pkg::DP_ADV_POP: begin
        if (adv_hit) begin
          // Time lands exactly on the popped note's end.
          time_nxt        = rd_end_r;
          count_nxt       = count_r - netq_pkg::CNT_W'(1);
          head_nxt        = slot_of(head_r, netq_pkg::CNT_W'(1));
          res_success_nxt = 1'b1;
          res_key_nxt     = rd_key_r;
          res_adv_nxt     = diff_r;
        end else begin
          time_nxt        = time_r + req_count_r;
          res_success_nxt = 1'b0;
          res_key_nxt     = '0;
          res_adv_nxt     = req_count_r;
        end
      end
      netq_pkg::DP_SKIP: begin
        time_nxt        = time_r + req_count_r;
        res_success_nxt = 1'b0;
        res_key_nxt     = '0;
        res_adv_nxt     = '0;
      end
      netq_pkg::DP_REFUSE: begin
        res_success_nxt = 1'b0;
        res_key_nxt     = '0;
        res_adv_nxt     = '0;
      end
      default: begin
      end
    endcase
  end

  // Queue state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r  <= '0;
      count_r <= '0;
      head_r  <= '0;
    end else begin
      time_r  <= time_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
    end
  end

  // Request capture, walk and advance working registers, and the result registers.
  always_ff @(posedge clk) begin
    res_success_r <= res_success_nxt;
    res_key_r     <= res_key_nxt;
    res_adv_r     <= res_adv_nxt;
    if (cmd.op == netq_pkg::DP_LOAD) begin
      req_cmd_r   <= in_command;
      req_key_r   <= in_note_key;
      req_end_r   <= time_r + in_duration;
      req_count_r <= in_sample_count;
    end
    if (cmd.op == netq_pkg::DP_LOOKUP) begin
      idx_r <= '0;
      ins_r <= 1'b0;
    end else if (cmd.op == netq_pkg::DP_WALK) begin
      idx_r <= idx_r + netq_pkg::CNT_W'(1);
      ins_r <= ins_r | place_new;
      if (ins_r || place_new) begin
        carry_end_r <= rd_end_r;
        carry_key_r <= rd_key_r;
      end
    end
    if (cmd.op == netq_pkg::DP_ADV_DIFF) begin
      diff_r <= rd_end_r - time_r;
    end
    if (cmd.out_load) begin
      out_success_r <= res_success_r;
      out_key_r     <= res_key_r;
      out_adv_r     <= res_adv_r;
    end
  end

  assign stat.req_cmd   = req_cmd_r;
  assign stat.full      = (count_r == netq_pkg::CNT_W'(netq_pkg::MAX_NOTES));
  assign stat.walk_last = walk_last;

  assign out_success          = out_success_r;
  assign out_ended_key        = out_key_r;
  assign out_samples_advanced = out_adv_r;

  // The fill count never passes the ring depth.
  `NETQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= netq_pkg::CNT_W'(netq_pkg::MAX_NOTES))
  // A refused request leaves time and queue untouched.
  `NETQ_ASSERT_NXT(a_refuse_keeps, clk, rst_n, cmd.op == netq_pkg::DP_REFUSE, (count_r == $past(count_r)) && (time_r == $past(time_r)) && (head_r == $past(head_r)))
  // Finishing a walk adds exactly one note.
  `NETQ_ASSERT_NXT(a_insert_grows, clk, rst_n, (cmd.op == netq_pkg::DP_WALK) && walk_last, count_r == $past(count_r) + netq_pkg::CNT_W'(1))
  // A popped note moves the head forward and time onto its end.
  `NETQ_ASSERT_NXT(a_pop_moves, clk, rst_n, (cmd.op == netq_pkg::DP_ADV_POP) && adv_hit, (count_r == $past(count_r) - netq_pkg::CNT_W'(1)) && (time_r == $past(rd_end_r)))

endmodule

// ===== hw/rtl/note_end_time_queue_core.sv =====
// ----------------------------------------------------------------------------
// note_end_time_queue_core
// Sample-time counter with a ring of pending notes kept sorted by end time.
// ----------------------------------------------------------------------------
//  Channel    Direction  Handshake      Payload
//  in_chan    sink       valid/ready    command, note_key, duration, sample_count
//  out_chan   source     valid/ready    success, ended_key, samples_advanced
//
//  One request is in work at a time; in_chan.ready is high while the sequencer
//  is idle. A start runs the insertion walk, which moves one ring entry per
//  cycle over every pending note, reading one position ahead of the one it
//  writes. An advance takes the time to the head note's end and then pops it or
//  moves time on; a skip or a refused request goes straight to its result.
//  A finished result waits in the output register while the next request is
//  taken; a stalled sink holds the sequencer only when the next result is ready.
//  Reset (rst_n, synchronous) clears time, fill count and head; ring contents
//  are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module note_end_time_queue_core (
  input  logic        clk,
  input  logic        rst_n,
  netq_in_if.sink     in_chan,
  netq_out_if.source  out_chan
);

  netq_pkg::dp_cmd_t  dp_cmd;
  netq_pkg::dp_stat_t dp_stat;

  // Request sequencer.
  netq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // Queue storage and arithmetic.
  netq_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (dp_cmd),
    .stat                 (dp_stat),
    .in_command           (in_chan.command),
    .in_note_key          (in_chan.note_key),
    .in_duration          (in_chan.duration),
    .in_sample_count      (in_chan.sample_count),
    .out_success          (out_chan.success),
    .out_ended_key        (out_chan.ended_key),
    .out_samples_advanced (out_chan.samples_advanced)
  );

endmodule

// ===== dv/note_end_time_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// note_end_time_queue_core_tb
// Self-checking bench for the note end time queue. A table of directed
// requests covers the time counter wrap, an empty queue, equal end times, a
// full queue and the unused command code. Random fill and drain sequences and
// noise follow. Every accepted request is run through a behavioral copy of
// the queue, and each result is compared field by field in order. Both
// channel sides idle at random.
// ----------------------------------------------------------------------------
module note_end_time_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int TOTAL_ITEMS    = 450;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIRECTED_ROWS  = 25;

  // The command code that the block refuses without touching its state.
  localparam logic [netq_pkg::CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [netq_pkg::TIME_W-1:0] TIME_MAX   = '1;

  typedef struct packed {
    logic [netq_pkg::CMD_W-1:0]  cmd;
    logic [netq_pkg::KEY_W-1:0]  key;
    logic [netq_pkg::TIME_W-1:0] dur;
    logic [netq_pkg::TIME_W-1:0] cnt;
  } note_req_t;

  typedef struct packed {
    logic                        success;
    logic [netq_pkg::KEY_W-1:0]  key;
    logic [netq_pkg::TIME_W-1:0] adv;
  } note_res_t;

  // A request row; when typed is set the listed result is expected as is.
  typedef struct packed {
    note_req_t req;
    logic      typed;
    note_res_t res;
  } note_row_t;

  typedef struct packed {
    logic      typed;
    note_res_t res;
  } typed_res_t;

  logic clk = 1'b0;
  logic rst_n;

  netq_in_if  in_chan ();
  netq_out_if out_chan ();

  note_end_time_queue_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Directed requests. The queue is filled to the brim with ties, then one
  // more start is refused and the two earliest notes are popped.
  note_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{netq_pkg::CMD_ADVANCE, 7'd0,   32'd0,    32'd0},    1'b1, '{1'b0, 7'd0,   32'd0}},
    '{'{netq_pkg::CMD_ADVANCE, 7'd0,   32'd0,    TIME_MAX}, 1'b1, '{1'b0, 7'd0,   TIME_MAX}},
    '{'{netq_pkg::CMD_SKIP,    7'd0,   32'd0,    32'd1},    1'b1, '{1'b0, 7'd0,   32'd0}},
    '{'{CMD_UNUSED,            7'd127, TIME_MAX, TIME_MAX}, 1'b1, '{1'b0, 7'd0,   32'd0}},
    '{'{netq_pkg::CMD_START,   7'd127, 32'd0,    32'd0},    1'b1, '{1'b1, 7'd0,   32'd0}},
    '{'{netq_pkg::CMD_ADVANCE, 7'd0,   32'd0,    32'd0},    1'b1, '{1'b1, 7'd127, 32'd0}},
    '{'{netq_pkg::CMD_START,   7'd0,   TIME_MAX, 32'd0},    1'b1, '{1'b1, 7'd0,   32'd0}},
    '{'{netq_pkg::CMD_START,   7'd1,   32'd300,  32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd2,   32'd200,  32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd3,   32'd300,  32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd4,   32'd100,  32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd5,   32'd200,  32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd6,   32'd300,  32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd7,   32'd0,    32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd8,   TIME_MAX, 32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd9,   32'd100,  32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd10,  32'd50,   32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd11,  32'd50,   32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd12,  32'd1,    32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd13,  32'd700,  32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd14,  32'd300,  32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd15,  32'd2,    32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_START,   7'd16,  32'd10,   32'd0},    1'b1, '{1'b0, 7'd0,   32'd0}},
    '{'{netq_pkg::CMD_ADVANCE, 7'd0,   32'd0,    32'd0},    1'b0, '0},
    '{'{netq_pkg::CMD_ADVANCE, 7'd0,   32'd0,    32'd30},   1'b0, '0}
  };

  // Behavioral copy of the queue state.
  logic [netq_pkg::TIME_W-1:0] now_time;
  logic [netq_pkg::TIME_W-1:0] ring_end [netq_pkg::MAX_NOTES];
  logic [netq_pkg::KEY_W-1:0]  ring_key [netq_pkg::MAX_NOTES];
  int                          ring_fill;
  int                          ring_first;

  note_res_t  pending_results [$];
  typed_res_t typed_results [$];

  int  mismatches;
  int  idle_cycles;
  int  items_sent;
  bit  hold_sink;
  int  starts_ok, starts_refused, pops, advances_idle, skips, unused_cmds, deepest;

  function automatic int ring_slot(input int idx);
    return (ring_first + idx) % netq_pkg::MAX_NOTES;
  endfunction

  // Work out the result of one request and move the queue state along.
  function automatic note_res_t predict_note_event(input note_req_t r);
    note_res_t                   res;
    logic [netq_pkg::TIME_W-1:0] end_at;
    logic [netq_pkg::TIME_W-1:0] until_due;
    int                          pos;
    int                          i;
    res = '0;
    case (r.cmd)
      netq_pkg::CMD_START: begin
        if (ring_fill < netq_pkg::MAX_NOTES) begin
          end_at = now_time + r.dur;
          pos = 0;
          // A new note goes ahead of every note ending at the same time.
          while (pos < ring_fill && ring_end[ring_slot(pos)] < end_at) pos++;
          for (i = ring_fill; i > pos; i--) begin
            ring_end[ring_slot(i)] = ring_end[ring_slot(i - 1)];
            ring_key[ring_slot(i)] = ring_key[ring_slot(i - 1)];
          end
          ring_end[ring_slot(pos)] = end_at;
          ring_key[ring_slot(pos)] = r.key;
          ring_fill++;
          res.success = 1'b1;
        end
      end
      netq_pkg::CMD_ADVANCE: begin
        res.adv = r.cnt;
        if (ring_fill != 0) begin
          until_due = ring_end[ring_first] - now_time;
          if (until_due <= r.cnt) begin
            res.success = 1'b1;
            res.key = ring_key[ring_first];
            res.adv = until_due;
            ring_fill--;
            ring_first = ring_slot(1);
          end
        end
        now_time = now_time + res.adv;
      end
      netq_pkg::CMD_SKIP: begin
        now_time = now_time + r.cnt;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Monitor: check results, predict accepted requests, keep the idle count.
  always @(posedge clk) begin : monitor
    note_res_t  want;
    note_res_t  got;
    note_req_t  req;
    typed_res_t row;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.success, out_chan.ended_key, out_chan.samples_advanced};
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding: success=%0b key=%0d adv=%0d",
                   $time, got.success, got.key, got.adv);
        end else begin
          want = pending_results.pop_front();
          if (got.success !== want.success) begin
            mismatches++;
            $display("%0t: success expected %0b actual %0b", $time, want.success, got.success);
          end
          if (got.key !== want.key) begin
            mismatches++;
            $display("%0t: ended_key expected %0d actual %0d", $time, want.key, got.key);
          end
          if (got.adv !== want.adv) begin
            mismatches++;
            $display("%0t: samples_advanced expected %0d actual %0d", $time, want.adv,
                     got.adv);
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        req = '{in_chan.command, in_chan.note_key, in_chan.duration, in_chan.sample_count};
        row = typed_results.pop_front();
        want = predict_note_event(req);
        case (req.cmd)
          netq_pkg::CMD_START:   if (want.success) starts_ok++; else starts_refused++;
          netq_pkg::CMD_ADVANCE: if (want.success) pops++; else advances_idle++;
          netq_pkg::CMD_SKIP:    skips++;
          default:               unused_cmds++;
        endcase
        if (ring_fill > deepest) deepest = ring_fill;
        pending_results.push_back(row.typed ? row.res : want);
      end
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or result.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: a random stall before each result, calm stretches, and one
  // long hold-off when the sender asks for it.
  initial begin : result_sink
    int stall;
    int calm_left;
    out_chan.ready <= 1'b0;
    calm_left = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_sink) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        if (calm_left > 0) begin
          calm_left--;
          stall = 0;
        end else begin
          if ($urandom_range(0, 9) == 0) calm_left = $urandom_range(5, 30);
          stall = $urandom_range(0, 19);
        end
        if (stall > 0) begin
          out_chan.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Offer one request, wait for its acceptance, then idle for a random gap.
  // With no gap, valid stays high for the next request.
  task automatic send_request(input note_req_t r, input bit calm, input typed_res_t row);
    int gap;
    typed_results.push_back(row);
    in_chan.valid        <= 1'b1;
    in_chan.command      <= r.cmd;
    in_chan.note_key     <= r.key;
    in_chan.duration     <= r.dur;
    in_chan.sample_count <= r.cnt;
    do @(posedge clk); while (!in_chan.ready);
    if (r.cmd != CMD_UNUSED) items_sent++;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_results_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Note length: mostly short, sometimes anywhere in the 32-bit range.
  function automatic logic [netq_pkg::TIME_W-1:0] note_length();
    case ($urandom_range(0, 7))
      0:       return TIME_MAX;
      1:       return '0;
      2:       return $urandom();
      3:       return $urandom_range(0, 50);
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  // Advance reach: often far enough to pop the earliest note.
  function automatic logic [netq_pkg::TIME_W-1:0] advance_reach();
    case ($urandom_range(0, 7))
      0, 1, 2: return TIME_MAX;
      3:       return $urandom();
      4:       return '0;
      default: return $urandom_range(0, 800);
    endcase
  endfunction

  // Stimulus, end of run and verdict.
  initial begin : request_source
    note_req_t                   r;
    logic [netq_pkg::TIME_W-1:0] last_dur;
    bit                          calm;
    bit                          hold_done;
    bit                          drain_done;
    int                          kind;
    int                          n;
    int                          j;
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.command      <= netq_pkg::CMD_START;
    in_chan.note_key     <= '0;
    in_chan.duration     <= '0;
    in_chan.sample_count <= '0;
    now_time = '0;
    ring_fill = 0;
    ring_first = 0;
    for (j = 0; j < netq_pkg::MAX_NOTES; j++) begin
      ring_end[j] = '0;
      ring_key[j] = '0;
    end
    last_dur = '0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    for (j = 0; j < DIRECTED_ROWS; j++) begin
      send_request(directed_rows[j].req, 1'b0,
                   '{directed_rows[j].typed, directed_rows[j].res});
    end

    // Random part: mostly fill and drain sequences, plus noise.
    while (items_sent < TOTAL_ITEMS) begin
      // Long hold-off on the result side while requests keep coming.
      if (!hold_done && items_sent >= 150) begin
        hold_done = 1'b1;
        hold_sink = 1'b1;
        repeat (12) begin
          r.cmd = $urandom_range(0, 1) ? netq_pkg::CMD_START : netq_pkg::CMD_ADVANCE;
          r.key = 7'($urandom_range(0, 127));
          r.dur = note_length();
          r.cnt = advance_reach();
          send_request(r, 1'b1, '0);
        end
      end
      // The sender pauses until everything is back.
      if (!drain_done && items_sent >= 300) begin
        drain_done = 1'b1;
        wait_results_drained();
      end
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        // Fill with notes, ties included, then pop them with the odd skip.
        n = $urandom_range(1, 18);
        repeat (n) begin
          r.cmd = netq_pkg::CMD_START;
          r.key = 7'($urandom_range(0, 127));
          r.dur = ($urandom_range(0, 3) == 0) ? last_dur : note_length();
          r.cnt = $urandom();
          last_dur = r.dur;
          send_request(r, calm, '0);
        end
        repeat ($urandom_range(1, 18)) begin
          r.cmd = ($urandom_range(0, 7) == 0) ? netq_pkg::CMD_SKIP : netq_pkg::CMD_ADVANCE;
          r.key = 7'($urandom_range(0, 127));
          r.dur = $urandom();
          r.cnt = (r.cmd == netq_pkg::CMD_SKIP) ? 32'($urandom_range(0, 300))
                                                : advance_reach();
          send_request(r, calm, '0);
        end
      end else if (kind <= 8) begin
        // Noise: any command with arbitrary fields.
        repeat ($urandom_range(1, 8)) begin
          r.cmd = ($urandom_range(0, 15) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
          r.key = 7'($urandom_range(0, 127));
          r.dur = $urandom_range(0, 1) ? $urandom() : note_length();
          r.cnt = $urandom_range(0, 1) ? $urandom() : advance_reach();
          send_request(r, calm, '0);
        end
      end else begin
        // Short advances that seldom reach a note, and small skips.
        repeat ($urandom_range(1, 6)) begin
          r.cmd = $urandom_range(0, 1) ? netq_pkg::CMD_ADVANCE : netq_pkg::CMD_SKIP;
          r.key = 7'($urandom_range(0, 127));
          r.dur = $urandom();
          r.cnt = $urandom_range(0, 20);
          send_request(r, calm, '0);
        end
      end
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("Requests: %0d starts taken, %0d refused when full, %0d notes popped,",
             starts_ok, starts_refused, pops);
    $display("%0d advances with nothing due, %0d skips, %0d unused codes, deepest queue %0d",
             advances_idle, skips, unused_cmds, deepest);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
